// ----- hw/rtl/pet_pkg.sv -----
// Package for the prefix-expression tokenizer: token kinds, lexer states,
// result beat layout, character classes and the transition table function.
// No dependencies.
package pet_pkg;

  // Default cap on the counted token length.
  localparam int MAX_TOKEN_LEN_DEF = 255;

  // Result queue depth.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Special characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // Keyword patterns, last character in the low byte
  localparam logic [23:0] KW_ADD    = 24'h616464;
  localparam logic [23:0] KW_SUB    = 24'h737562;
  localparam logic [31:0] KW_MULT   = 32'h6D756C74;
  localparam logic [47:0] KW_CONCAT = 48'h636F6E636174;

  localparam logic [35:0] POS_LIMIT = 36'd2147483647;
  localparam logic [35:0] NEG_LIMIT = 36'd2147483648;

  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_ADD     = 4'd1,
    KIND_MULT    = 4'd2,
    KIND_SUB     = 4'd3,
    KIND_CONCAT  = 4'd4,
    KIND_INTEGER = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_MINUS   = 4'd8,
    KIND_STRING  = 4'd9,
    KIND_ERROR   = 4'd10
  } kind_t;

  typedef enum logic [3:0] {
    S_START  = 4'd0,
    S_IDENT  = 4'd1,
    S_UINT   = 4'd2,
    S_LPAREN = 4'd3,
    S_RPAREN = 4'd4,
    S_MINUS  = 4'd5,
    S_STRING = 4'd6,
    S_STREND = 4'd7
  } lex_state_t;

  typedef enum logic [1:0] {
    ACT_ERR  = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_EMIT = 2'd2
  } act_t;

  typedef struct packed {
    act_t       act;
    lex_state_t nx;
  } trans_t;

  // One result beat
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        ovf;
    logic [7:0]  len;
    logic        last;
  } res_t;

  // Lexer to queue: results of the current character
  typedef struct packed {
    res_t       res0;
    res_t       res1;
    logic [1:0] n_res;
    logic       halted;
  } lex_out_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    case (c)
      "+", "-", "*", "/", "(", ")", " ", "[", "]", "\n",
      "=", "%", "&", ";", "{", "}", ">", "<": d = 1'b1;
      default:                                 d = 1'b0;
    endcase
    return d;
  endfunction

  // Transition table: action and next state for a state and character
  function automatic trans_t table_action(input lex_state_t st, input logic [7:0] c);
    trans_t t;
    logic   ld;
    logic   dol;
    ld    = is_letter(c) || is_digit(c) || is_delim(c);
    dol   = (c == CH_DOLLAR);
    t.act = ACT_ERR;
    t.nx  = S_START;
    unique case (st)
      S_START: begin
        if (is_letter(c)) begin
          t = '{ACT_MOVE, S_IDENT};
        end else if (is_digit(c)) begin
          t = '{ACT_MOVE, S_UINT};
        end else if (c == CH_MINUS) begin
          t = '{ACT_MOVE, S_MINUS};
        end else if (c == CH_LPAREN) begin
          t = '{ACT_MOVE, S_LPAREN};
        end else if (c == CH_RPAREN) begin
          t = '{ACT_MOVE, S_RPAREN};
        end else if (c == CH_SPACE) begin
          t = '{ACT_MOVE, S_START};
        end else if (c == CH_QUOTE) begin
          t = '{ACT_MOVE, S_STRING};
        end
      end
      S_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          t = '{ACT_MOVE, S_IDENT};
        end else if (c == "}" || c == ">" || c == "<") begin
          t.act = ACT_ERR;
        end else if (is_delim(c) || dol) begin
          t.act = ACT_EMIT;
        end
      end
      S_UINT: begin
        if (is_digit(c)) begin
          t = '{ACT_MOVE, S_UINT};
        end else if (is_delim(c) || dol) begin
          t.act = ACT_EMIT;
        end
      end
      S_LPAREN, S_RPAREN: begin
        if (ld || dol) t.act = ACT_EMIT;
      end
      S_MINUS: begin
        if (is_digit(c)) begin
          t = '{ACT_MOVE, S_MINUS};
        end else if (ld || dol) begin
          t.act = ACT_EMIT;
        end
      end
      S_STRING: begin
        if (ld) begin
          t = '{ACT_MOVE, S_STRING};
        end else if (c == CH_QUOTE) begin
          t = '{ACT_MOVE, S_STREND};
        end else if (dol) begin
          t.act = ACT_EMIT;
        end
      end
      S_STREND: begin
        if (ld || dol || c == CH_QUOTE) t.act = ACT_EMIT;
      end
      default: t.act = ACT_ERR;
    endcase
    return t;
  endfunction

endpackage

// ----- hw/rtl/pet_lexer.sv -----
// Tokenizer core: lexer state, value accumulator, keyword window and
// length counter, plus the per-character step logic. Uses pet_pkg.
module pet_lexer
  import pet_pkg::*;
#(
  parameter int LEN_CAP = MAX_TOKEN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] character,
  output lex_out_t   lex_out
);

  localparam logic [7:0] LenCapV = 8'(LEN_CAP);

  // Token state registers
  lex_state_t  st;
  logic        halted;
  logic [31:0] acc;
  logic        neg;
  logic        ovf;
  logic [55:0] win;
  logic [7:0]  len;

  lex_state_t  st_next;
  logic        halted_next;
  logic [31:0] acc_next;
  logic        neg_next;
  logic        ovf_next;
  logic [55:0] win_next;
  logic [7:0]  len_next;

  // Step logic for one character
  always_comb begin
    trans_t      t1;
    trans_t      t2;
    logic        emit;
    lex_state_t  from;
    res_t        tok;
    res_t        err;
    logic [35:0] v;
    logic [35:0] lim;

    t1   = table_action(st, character);
    emit = (t1.act == ACT_EMIT);

    // Token built from the current registers
    tok.kind  = KIND_STRING;
    tok.value = '0;
    tok.ovf   = 1'b0;
    tok.len   = len;
    tok.last  = 1'b0;
    unique case (st)
      S_IDENT: begin
        if (len == 8'd3 && win[23:0] == KW_ADD) tok.kind = KIND_ADD;
        else if (len == 8'd4 && win[31:0] == KW_MULT) tok.kind = KIND_MULT;
        else if (len == 8'd3 && win[23:0] == KW_SUB) tok.kind = KIND_SUB;
        else if (len == 8'd6 && win[47:0] == KW_CONCAT) tok.kind = KIND_CONCAT;
        else tok.kind = KIND_IDENT;
      end
      S_UINT, S_MINUS: begin
        if (st == S_MINUS && len < 8'd2) begin
          tok.kind = KIND_MINUS;
        end else begin
          tok.kind  = KIND_INTEGER;
          tok.value = neg ? (32'd0 - acc) : acc;
          tok.ovf   = ovf;
        end
      end
      S_LPAREN: tok.kind = KIND_LPAREN;
      S_RPAREN: tok.kind = KIND_RPAREN;
      default:  tok.kind = KIND_STRING;
    endcase

    err.kind  = KIND_ERROR;
    err.value = '0;
    err.ovf   = 1'b0;
    err.len   = '0;
    err.last  = 1'b1;

    // Base state: cleared after an emitted token
    st_next     = emit ? S_START : st;
    from        = st_next;
    halted_next = halted;
    acc_next    = emit ? '0 : acc;
    neg_next    = emit ? 1'b0 : neg;
    ovf_next    = emit ? 1'b0 : ovf;
    win_next    = emit ? '0 : win;
    len_next    = emit ? '0 : len;
    t2          = emit ? table_action(S_START, character) : t1;

    lex_out.res0   = tok;
    lex_out.res1   = err;
    lex_out.n_res  = 2'd0;
    lex_out.halted = halted;

    v   = '0;
    lim = '0;

    if (halted) begin
      lex_out.n_res = 2'd0;
    end else if (emit && character == CH_DOLLAR) begin
      // Terminator closes the token and is consumed
      lex_out.res0.last = 1'b1;
      lex_out.n_res     = 2'd1;
    end else if (t2.act == ACT_MOVE) begin
      // Absorb the character into the token
      if (t2.nx != S_START && character != CH_QUOTE) begin
        if (len_next < LenCapV) len_next = len_next + 8'd1;
        win_next = {win_next[47:0], character};
      end
      if (from == S_START && character == CH_MINUS) neg_next = 1'b1;
      if (is_digit(character) && (t2.nx == S_UINT || t2.nx == S_MINUS)) begin
        lim = neg_next ? NEG_LIMIT : POS_LIMIT;
        v   = {1'b0, acc_next, 3'b000} + {3'b000, acc_next, 1'b0}
            + {28'd0, character - CH_ZERO};
        if (v > lim) begin
          v        = lim;
          ovf_next = 1'b1;
        end
        acc_next = v[31:0];
      end
      st_next = t2.nx;
      if (emit) begin
        lex_out.res0.last = 1'b1;
        lex_out.n_res     = 2'd1;
      end
    end else begin
      // Lexical error, alone or after the token just ended
      halted_next = 1'b1;
      if (emit) begin
        lex_out.n_res = 2'd2;
      end else begin
        lex_out.res0  = err;
        lex_out.n_res = 2'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_START;
      halted <= 1'b0;
      acc    <= '0;
      neg    <= 1'b0;
      ovf    <= 1'b0;
      win    <= '0;
      len    <= '0;
    end else if (fire) begin
      st     <= st_next;
      halted <= halted_next;
      acc    <= acc_next;
      neg    <= neg_next;
      ovf    <= ovf_next;
      win    <= win_next;
      len    <= len_next;
    end
  end

endmodule

// ----- hw/rtl/pet_res_fifo.sv -----
// Result queue: takes zero, one or two result beats per cycle and hands
// them out one beat at a time. Uses pet_pkg.
module pet_res_fifo
  import pet_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  res_t       d0,
  input  res_t       d1,
  input  logic       pop,
  output res_t       q,
  output logic       q_valid,
  output logic       room2
);

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign q       = mem[rp];
  assign q_valid = (cnt != '0);
  assign room2   = (cnt <= (QAW+1)'(QDEPTH - 2));

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= d0;
    if (push_n == 2'd2) mem[wp + QAW'(1)] <= d1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + QAW'(push_n);
      if (pop) rp <= rp + QAW'(1);
      cnt <= cnt + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/prefix_expression_tokenizer.sv -----
// Top level of the prefix-expression tokenizer: input register, lexer core
// and result queue. Uses pet_pkg, pet_lexer and pet_res_fifo.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata[7:0] character
//  m_      | out | m_tvalid/m_tready  | tdata int_value, int_overflow,
//          |     |                    | text_length; tuser token_kind;
//          |     |                    | tlast last_of_run
//
// One character per cycle while the queue has room: a character is held
// in the input register for its table step; results land in a four-beat queue.
// A character giving two results (a token then an error) needs two output
// beats; the step waits whenever the queue has fewer than two free slots.
// rst (synchronous) returns the lexer to the start state and empties the
// queue. After a lexical error characters are taken and give no beats.
module prefix_expression_tokenizer
  import pet_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] int_value, [32] int_overflow,
                                 // [40:33] text_length, [47:41] zero
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // last_of_run
);

  localparam int LenCap = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

  logic       in_valid;
  logic [7:0] in_char;
  logic       room2;
  logic       fire;
  lex_out_t   lex_out;
  logic [1:0] push_n;
  res_t       q;

  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || fire;
  assign push_n   = fire ? lex_out.n_res : 2'd0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_char <= s_tdata;
  end

  pet_lexer #(
    .LEN_CAP (LenCap)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .character (in_char),
    .lex_out   (lex_out)
  );

  pet_res_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_n  (push_n),
    .d0      (lex_out.res0),
    .d1      (lex_out.res1),
    .pop     (m_tvalid && m_tready),
    .q       (q),
    .q_valid (m_tvalid),
    .room2   (room2)
  );

  // Output beat packing
  assign m_tdata = {7'd0, q.len, q.ovf, q.value};
  assign m_tuser = q.kind;
  assign m_tlast = q.last;

`ifndef NO_ASSERTIONS
  // No results once halted
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (fire && lex_out.halted) |-> (lex_out.n_res == 2'd0))
    else $error("result produced while halted");

  // A second result is always the lexical error, closing the run
  a_pair_err: assert property (@(posedge clk) disable iff (rst)
    (fire && lex_out.n_res == 2'd2) |->
      (lex_out.res1.kind == KIND_ERROR && lex_out.res1.last && !lex_out.res0.last))
    else $error("two-result step without trailing error");

  // A single result closes its run
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (fire && lex_out.n_res == 2'd1) |-> lex_out.res0.last)
    else $error("single result not marked last");

  // An error halts the lexer on the next cycle
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (fire && lex_out.n_res != 2'd0 &&
     (lex_out.res0.kind == KIND_ERROR || lex_out.n_res == 2'd2)) |=> lex_out.halted)
    else $error("lexer not halted after error");
`endif

endmodule
